// ===== src/jtsn_pkg.sv =====
// ----------------------------------------------------------------------------
// jtsn_pkg: shared definitions for the jtag tap state navigator
// tap state encoding, transition tables, action codes and path limits
// ----------------------------------------------------------------------------
package jtsn_pkg;

  localparam int unsigned NUM_STATES     = 16;
  localparam int unsigned STATE_W        = 4;
  localparam int unsigned PATH_MAX_MOVES = 8;
  localparam int unsigned MOVE_CNT_W     = $clog2(PATH_MAX_MOVES);
  // the tap graph has diameter 8, so eight parallel relaxation passes settle
  localparam int unsigned DIST_PASSES    = 8;
  localparam int unsigned PASS_CNT_W     = $clog2(DIST_PASSES);
  localparam int unsigned DIST_W         = 4;
  localparam logic [DIST_W-1:0] DIST_FAR = '1;

  localparam logic [STATE_W-1:0] TAP_TLR = 4'd0;

  localparam logic ACT_GOTO = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [STATE_W-1:0] tap_state_t;
  typedef logic [DIST_W-1:0]  dist_t;

  // next state with tms low
  function automatic tap_state_t next_on_low(input tap_state_t s);
    tap_state_t n;
    unique case (s)
      4'd0:    n = 4'd1;
      4'd1:    n = 4'd1;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd4;
      4'd4:    n = 4'd4;
      4'd5:    n = 4'd6;
      4'd6:    n = 4'd6;
      4'd7:    n = 4'd4;
      4'd8:    n = 4'd1;
      4'd9:    n = 4'd10;
      4'd10:   n = 4'd11;
      4'd11:   n = 4'd11;
      4'd12:   n = 4'd13;
      4'd13:   n = 4'd13;
      4'd14:   n = 4'd11;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // next state with tms high
  function automatic tap_state_t next_on_high(input tap_state_t s);
    tap_state_t n;
    unique case (s)
      4'd0:    n = 4'd0;
      4'd1:    n = 4'd2;
      4'd2:    n = 4'd9;
      4'd3:    n = 4'd5;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd8;
      4'd6:    n = 4'd7;
      4'd7:    n = 4'd8;
      4'd8:    n = 4'd2;
      4'd9:    n = 4'd0;
      4'd10:   n = 4'd12;
      4'd11:   n = 4'd12;
      4'd12:   n = 4'd15;
      4'd13:   n = 4'd14;
      4'd14:   n = 4'd15;
      default: n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic tap_state_t tap_move(input tap_state_t s, input logic tms);
    return tms ? next_on_high(s) : next_on_low(s);
  endfunction

endpackage

// ===== src/jtag_tap_state_navigator_unit.sv =====
// ----------------------------------------------------------------------------
// jtag_tap_state_navigator_unit: tap state tracker and shortest path walker
//
// Input beats arrive on the s_axis channel. tuser selects the action: a step
// applies tdata's tms bit once, a goto walks the tap state to tdata's target
// state along a shortest tms sequence, preferring tms 0 at the earliest move.
// Results leave on the m_axis channel, one beat per tck move, tlast on the
// final beat of an item; tuser carries the clock pulse flag, low only for a
// goto to the state already held (a single beat with no tck move).
// Step and same-state goto: result beat registered in the cycle after acceptance.
// Goto elsewhere: eight relaxation passes build the distance map toward the
// target (one pass per cycle over all sixteen states), then one move per
// cycle while the output register is free or being drained; each move
// registers one result beat.
// One item is in flight at a time; the next is accepted once the last result
// is registered and the output register is free or being drained.
// A stall on m_axis holds the output register and pauses the walk.
// Reset puts the tracked state in test-logic-reset and empties the output.
// ----------------------------------------------------------------------------
module jtag_tap_state_navigator_unit
  import jtsn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [3:0] target_state, [4] tms_in, [7:5] zero
  input  logic       s_axis_tuser_i,   // [0] action
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] tms_out, [4:1] state_after, [7:5] zero
  output logic       m_axis_tuser_o,   // [0] clock_pulse
  output logic       m_axis_tlast_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RELAX = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0]             st_q, st_d;
  tap_state_t             tap_q, tap_d;
  tap_state_t             tgt_q, tgt_d;
  logic [PASS_CNT_W-1:0]  pass_q, pass_d;
  logic [MOVE_CNT_W-1:0]  mcnt_q, mcnt_d;
  dist_t                  dist_q [NUM_STATES];
  dist_t                  dist_d [NUM_STATES];

  logic       out_valid_q, out_valid_d;
  logic       out_tms_q, out_tms_d;
  tap_state_t out_state_q, out_state_d;
  logic       out_pulse_q, out_pulse_d;
  logic       out_last_q, out_last_d;

  logic                  out_free;
  logic                  s_accept;
  logic [NUM_STATES-1:0] pref_hi;
  logic                  walk_tms;
  tap_state_t            walk_next;
  tap_state_t            in_target;
  logic                  in_tms;
  tap_state_t            step_next;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == ST_IDLE) && out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_target       = s_axis_tdata_i[3:0];
  assign in_tms          = s_axis_tdata_i[4];
  assign step_next       = tap_move(tap_q, in_tms);

  // tms 1 is taken only where tms 0 leaves every shortest path
  always_comb begin
    for (int s = 0; s < NUM_STATES; s++) begin
      pref_hi[s] = ({1'b0, dist_q[next_on_low(STATE_W'(s))]} + 5'd1)
                   != {1'b0, dist_q[s]};
    end
  end

  assign walk_tms  = pref_hi[tap_q];
  assign walk_next = tap_move(tap_q, walk_tms);

  always_comb begin
    st_d        = st_q;
    tap_d       = tap_q;
    tgt_d       = tgt_q;
    pass_d      = pass_q;
    mcnt_d      = mcnt_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_tms_d   = out_tms_q;
    out_state_d = out_state_q;
    out_pulse_d = out_pulse_q;
    out_last_d  = out_last_q;

    unique case (st_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == ACT_STEP) begin
            tap_d       = step_next;
            out_valid_d = 1'b1;
            out_tms_d   = in_tms;
            out_state_d = step_next;
            out_pulse_d = 1'b1;
            out_last_d  = 1'b1;
          end else if (in_target == tap_q) begin
            out_valid_d = 1'b1;
            out_tms_d   = 1'b0;
            out_state_d = tap_q;
            out_pulse_d = 1'b0;
            out_last_d  = 1'b1;
          end else begin
            tgt_d  = in_target;
            pass_d = '0;
            mcnt_d = '0;
            for (int s = 0; s < NUM_STATES; s++) begin
              dist_d[s] = (STATE_W'(s) == in_target) ? '0 : DIST_FAR;
            end
            st_d = ST_RELAX;
          end
        end
      end
      ST_RELAX: begin
        for (int s = 0; s < NUM_STATES; s++) begin
          dist_t d0, d1, best;
          d0   = dist_q[next_on_low(STATE_W'(s))];
          d1   = dist_q[next_on_high(STATE_W'(s))];
          best = (d0 < d1) ? d0 : d1;
          if (STATE_W'(s) != tgt_q && best != DIST_FAR
              && ({1'b0, best} + 5'd1) < {1'b0, dist_q[s]}) begin
            dist_d[s] = best + 4'd1;
          end
        end
        pass_d = pass_q + 1'b1;
        if (pass_q == PASS_CNT_W'(DIST_PASSES - 1)) begin
          st_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          tap_d       = walk_next;
          mcnt_d      = mcnt_q + 1'b1;
          out_valid_d = 1'b1;
          out_tms_d   = walk_tms;
          out_state_d = walk_next;
          out_pulse_d = 1'b1;
          out_last_d  = (walk_next == tgt_q)
                        || (mcnt_q == MOVE_CNT_W'(PATH_MAX_MOVES - 1));
          if (out_last_d) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      tap_q       <= TAP_TLR;
      pass_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      tap_q       <= tap_d;
      pass_q      <= pass_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    dist_q      <= dist_d;
    out_tms_q   <= out_tms_d;
    out_state_q <= out_state_d;
    out_pulse_q <= out_pulse_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_state_q, out_tms_q};
  assign m_axis_tuser_o  = out_pulse_q;
  assign m_axis_tlast_o  = out_last_q;

  // a beat with no tck move always closes its item
  a_nopulse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("no-pulse beat without tlast");

  // a finished walk leaves the tap at the target
  a_walk_reaches_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && $past(st_q) == ST_WALK) |-> (tap_q == tgt_q))
    else $error("walk ended away from target");

  // the target keeps distance zero through relaxation
  a_target_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RELAX) |-> (dist_q[tgt_q] == '0))
    else $error("target distance disturbed");

  // every walk beat moves the tap and carries a pulse
  a_walk_beat_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(st_q) == ST_WALK && $rose(out_valid_q)) |-> out_pulse_q)
    else $error("walk beat without clock pulse");

endmodule

// ===== bench/tb_jtag_tap_state_navigator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jtag_tap_state_navigator_unit: self-checking bench for the tap navigator
// Drives step and goto commands on s_axis. A tracker class keeps its own copy
// of the tap state, plans the shortest tms walk for each goto, and compares
// every m_axis beat in order. Both stream sides idle at random in phases.
// ----------------------------------------------------------------------------
module tb_jtag_tap_state_navigator_unit
  import jtsn_pkg::*;
;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NO_PATH = 255;

  // tap transition tables, state numbering as in the package
  localparam tap_state_t TMS0_NEXT [16] = '{
    4'd1, 4'd1, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4,
    4'd1, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd11, 4'd1
  };
  localparam tap_state_t TMS1_NEXT [16] = '{
    4'd0, 4'd2, 4'd9, 4'd5, 4'd5, 4'd8, 4'd7, 4'd8,
    4'd2, 4'd0, 4'd12, 4'd12, 4'd15, 4'd14, 4'd15, 4'd2
  };

  typedef struct packed {
    logic       tms;
    tap_state_t st;
    logic       pulse;
    logic       last;
  } tap_move_t;

  class tap_path_tracker;
    tap_state_t cur_state;
    tap_move_t  moves_due[$];
    int         mismatches;

    function new();
      cur_state  = TAP_TLR;
      mismatches = 0;
    endfunction

    function void push_move(logic tms, logic pulse, logic last);
      tap_move_t m;
      m.tms   = tms;
      m.st    = cur_state;
      m.pulse = pulse;
      m.last  = last;
      moves_due.push_back(m);
    endfunction

    // plans the tms walk caused by one accepted command
    function void note_command(logic act, tap_state_t tgt, logic tms);
      int   hops_left [16];
      int   best;
      int   hops;
      logic bit_val;
      if (act == ACT_STEP) begin
        cur_state = tms ? TMS1_NEXT[cur_state] : TMS0_NEXT[cur_state];
        push_move(tms, 1'b1, 1'b1);
        return;
      end
      if (tgt == cur_state) begin
        push_move(1'b0, 1'b0, 1'b1);
        return;
      end
      foreach (hops_left[s]) hops_left[s] = NO_PATH;
      hops_left[tgt] = 0;
      repeat (16) begin
        for (int s = 0; s < 16; s++) begin
          best = hops_left[TMS0_NEXT[s]] < hops_left[TMS1_NEXT[s]] ?
                 hops_left[TMS0_NEXT[s]] : hops_left[TMS1_NEXT[s]];
          if (s != tgt && best < NO_PATH && best + 1 < hops_left[s])
            hops_left[s] = best + 1;
        end
      end
      hops = hops_left[cur_state];
      if (hops > PATH_MAX_MOVES) hops = PATH_MAX_MOVES;
      // take tms 0 whenever it stays on a shortest path
      for (int k = 0; k < hops; k++) begin
        bit_val = (hops_left[TMS0_NEXT[cur_state]] + 1 == hops_left[cur_state]) ?
                  1'b0 : 1'b1;
        cur_state = bit_val ? TMS1_NEXT[cur_state] : TMS0_NEXT[cur_state];
        push_move(bit_val, 1'b1, (k + 1 == hops));
      end
    endfunction

    function void check_move(logic tms, tap_state_t st, logic pulse, logic last);
      tap_move_t want;
      if (moves_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat tms=%0d state=%0d pulse=%0d last=%0d",
                   $realtime, tms, st, pulse, last);
        return;
      end
      want = moves_due.pop_front();
      if (want.tms !== tms || want.st !== st || want.pulse !== pulse ||
          want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch expected tms=%0d state=%0d pulse=%0d last=%0d,",
                   $realtime, want.tms, want.st, want.pulse, want.last,
                   " got tms=%0d state=%0d pulse=%0d last=%0d",
                   tms, st, pulse, last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [3:0] target_state, [4] tms_in, [7:5] zero
  logic       s_axis_tuser_i;   // [0] action
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [0] tms_out, [4:1] state_after, [7:5] zero
  logic       m_axis_tuser_o;   // [0] clock_pulse
  logic       m_axis_tlast_o;

  tap_path_tracker tracker;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_cycles;

  jtag_tap_state_navigator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_move(m_axis_tdata_o[0], m_axis_tdata_o[4:1],
                         m_axis_tuser_o, m_axis_tlast_o);
  end

  // no beat moving on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_command(input logic act, input tap_state_t tgt, input logic tms);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {3'b000, tms, tgt};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_command(act, tgt, tms);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    logic act;
    repeat (count) begin
      act = ($urandom_range(0, 99) < 60) ? ACT_GOTO : ACT_STEP;
      send_command(act, tap_state_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    stall_cycles    = 0;
    src_idle_pct    = 35;
    sink_idle_pct   = 84;
    tracker         = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // goto to the state already held, then steps with ignored target bits set
    send_command(ACT_GOTO, TAP_TLR, 1'b1);
    send_command(ACT_STEP, 4'd15, 1'b1);
    send_command(ACT_STEP, 4'd10, 1'b0);
    send_command(ACT_STEP, 4'd5, 1'b1);
    // every target in turn, tms_in set on odd ones to show it is ignored
    for (int t = 0; t < 16; t++)
      send_command(ACT_GOTO, tap_state_t'(t), t[0]);
    send_command(ACT_GOTO, 4'd15, 1'b0);
    send_command(ACT_GOTO, 4'd6, 1'b1);
    send_command(ACT_GOTO, 4'd13, 1'b0);

    send_random(140);
    src_idle_pct  = 84;
    sink_idle_pct = 35;
    send_random(140);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(120);
    s_axis_tvalid_i <= 1'b0;

    while (tracker.moves_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jtsn_pkg.sv
src/jtag_tap_state_navigator_unit.sv
bench/tb_jtag_tap_state_navigator_unit.sv
